@@ hdl/ppgd_pkg.sv @@
// Shared types and constants of the push-pull gesture detector.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ppgd_pkg;

   localparam int TIME_W  = 16;
   localparam int VEL_W   = 16;
   localparam int FRAME_W = 10;
   localparam int PHASE_W = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [PHASE_W-1:0] {
      PH_WAIT   = 3'd0,
      PH_IN     = 3'd1,
      PH_BOOST  = 3'd2,
      PH_OUT    = 3'd3,
      PH_TOGGLE = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      REG_PUSH_VELOCITY_MIN = 3'd0,
      REG_PUSH_TIME_MIN     = 3'd1,
      REG_PULL_VELOCITY_MAX = 3'd2,
      REG_PULL_TIME_MIN     = 3'd3,
      REG_GESTURE_TIME_MAX  = 3'd4
   } reg_index_type;

   localparam logic signed [VEL_W-1:0] PUSH_VELOCITY_MIN_RST = 16'sd474;
   localparam logic [TIME_W-1:0]       PUSH_TIME_MIN_RST     = 16'd50;
   localparam logic signed [VEL_W-1:0] PULL_VELOCITY_MAX_RST = -16'sd320;
   localparam logic [TIME_W-1:0]       PULL_TIME_MIN_RST     = 16'd30;
   localparam logic [TIME_W-1:0]       GESTURE_TIME_MAX_RST  = 16'd5000;

   typedef struct packed {
      logic signed [VEL_W-1:0] push_velocity_min;
      logic [TIME_W-1:0]       push_time_min;
      logic signed [VEL_W-1:0] pull_velocity_max;
      logic [TIME_W-1:0]       pull_time_min;
      logic [TIME_W-1:0]       gesture_time_max;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic                    use_right_hand;
      logic signed [VEL_W-1:0] last_velocity;
      logic [TIME_W-1:0]       gesture_elapsed;
      logic [TIME_W-1:0]       phase_elapsed;
      logic                    confidence;
   } state_type;

   localparam state_type STATE_CLEARED = '{
      phase:           PH_WAIT,
      use_right_hand:  1'b0,
      last_velocity:   '0,
      gesture_elapsed: '0,
      phase_elapsed:   '0,
      confidence:      1'b0
   };

endpackage

@@ hdl/ppgd_stream_if.sv @@
// Valid/ready channel interfaces for frame items and result items.
// Depends on ppgd_pkg for field widths.
`timescale 1ns / 1ps

interface ppgd_req_if
   import ppgd_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [FRAME_W-1:0]        frame_time;
   logic signed [VEL_W-1:0]   left_velocity;
   logic signed [VEL_W-1:0]   right_velocity;

   modport source (output valid, frame_time, left_velocity, right_velocity, input ready);
   modport sink   (input valid, frame_time, left_velocity, right_velocity, output ready);
endinterface

interface ppgd_rsp_if
   import ppgd_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [PHASE_W-1:0]        phase;
   logic                      confidence;
   logic                      right_hand_tracked;
   logic signed [VEL_W-1:0]   tracked_velocity;

   modport source (output valid, phase, confidence, right_hand_tracked, tracked_velocity,
                   input ready);
   modport sink   (input valid, phase, confidence, right_hand_tracked, tracked_velocity,
                   output ready);
endinterface

@@ hdl/push_pull_gesture_detector_unit.sv @@
// The result item of an accepted frame item appears on rsp_ch in the next cycle.
// Throughput: one frame item per cycle; the single result register sets the pace,
//   and a new item is taken whenever that register is empty or being drained.
// Reset (synchronous, active high): machine returns to waiting with all times,
//   velocity and confidence cleared, result register empty, registers at defaults.
// Depends on ppgd_pkg, ppgd_stream_if, ppgd_csr and ppgd_core.
`timescale 1ns / 1ps

module push_pull_gesture_detector_unit
   import ppgd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ppgd_req_if.sink              req_ch,
   ppgd_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type   cfg;
   state_type state_ff, state_in;
   logic      accept;

   // Result register: valid bit is control, payload holds the updated state.
   logic                    rsp_valid_ff, rsp_valid_in;
   phase_type               rsp_phase_ff;
   logic                    rsp_conf_ff;
   logic                    rsp_right_ff;
   logic signed [VEL_W-1:0] rsp_vel_ff;

   ppgd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // One frame of phase logic between the state register and the result register.
   ppgd_core u_core (
      .cur            (state_ff),
      .cfg            (cfg),
      .frame_time     (req_ch.frame_time),
      .left_velocity  (req_ch.left_velocity),
      .right_velocity (req_ch.right_velocity),
      .nxt            (state_in)
   );

   // Take a new item while the result register is free or being taken this cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEARED;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture the updated state as the result payload; hold it otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_phase_ff <= state_in.phase;
         rsp_conf_ff  <= state_in.confidence;
         rsp_right_ff <= state_in.use_right_hand;
         rsp_vel_ff   <= state_in.last_velocity;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.phase              = rsp_phase_ff;
   assign rsp_ch.confidence         = rsp_conf_ff;
   assign rsp_ch.right_hand_tracked = rsp_right_ff;
   assign rsp_ch.tracked_velocity   = rsp_vel_ff;

endmodule

@@ hdl/ppgd_csr.sv @@
// APB-style configuration registers of the gesture detector.
// Depends on ppgd_pkg.
`timescale 1ns / 1ps

module ppgd_csr
   import ppgd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_PUSH_VELOCITY_MIN: cfg_in.push_velocity_min = pwdata[VEL_W-1:0];
            REG_PUSH_TIME_MIN:     cfg_in.push_time_min     = pwdata[TIME_W-1:0];
            REG_PULL_VELOCITY_MAX: cfg_in.pull_velocity_max = pwdata[VEL_W-1:0];
            REG_PULL_TIME_MIN:     cfg_in.pull_time_min     = pwdata[TIME_W-1:0];
            REG_GESTURE_TIME_MAX:  cfg_in.gesture_time_max  = pwdata[TIME_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.push_velocity_min <= PUSH_VELOCITY_MIN_RST;
         cfg_ff.push_time_min     <= PUSH_TIME_MIN_RST;
         cfg_ff.pull_velocity_max <= PULL_VELOCITY_MAX_RST;
         cfg_ff.pull_time_min     <= PULL_TIME_MIN_RST;
         cfg_ff.gesture_time_max  <= GESTURE_TIME_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back zero-extended register contents.
   always_comb begin
      case (index)
         REG_PUSH_VELOCITY_MIN: prdata = {16'd0, cfg_ff.push_velocity_min};
         REG_PUSH_TIME_MIN:     prdata = {16'd0, cfg_ff.push_time_min};
         REG_PULL_VELOCITY_MAX: prdata = {16'd0, cfg_ff.pull_velocity_max};
         REG_PULL_TIME_MIN:     prdata = {16'd0, cfg_ff.pull_time_min};
         REG_GESTURE_TIME_MAX:  prdata = {16'd0, cfg_ff.gesture_time_max};
         default:               prdata = '0;
      endcase
   end

endmodule

@@ hdl/ppgd_core.sv @@
// Next-state logic of the five-phase push-pull machine for one frame.
// Depends on ppgd_pkg.
`timescale 1ns / 1ps

module ppgd_core
   import ppgd_pkg::*;
(
   input  state_type               cur,
   input  cfg_type                 cfg,
   input  logic [FRAME_W-1:0]      frame_time,
   input  logic signed [VEL_W-1:0] left_velocity,
   input  logic signed [VEL_W-1:0] right_velocity,
   output state_type               nxt
);

   logic [TIME_W:0]         gesture_sum, phase_sum;
   logic [TIME_W-1:0]       gesture_sat, phase_sat;
   logic signed [VEL_W-1:0] tracked;

   assign gesture_sum = {1'b0, cur.gesture_elapsed} + {{(TIME_W+1-FRAME_W){1'b0}}, frame_time};
   assign phase_sum   = {1'b0, cur.phase_elapsed} + {{(TIME_W+1-FRAME_W){1'b0}}, frame_time};
   assign gesture_sat = gesture_sum[TIME_W] ? '1 : gesture_sum[TIME_W-1:0];
   assign phase_sat   = phase_sum[TIME_W] ? '1 : phase_sum[TIME_W-1:0];
   assign tracked     = cur.use_right_hand ? right_velocity : left_velocity;

   always_comb begin
      nxt = cur;
      case (cur.phase)
         PH_TOGGLE: nxt = STATE_CLEARED;
         PH_WAIT: begin
            if (left_velocity >= cfg.push_velocity_min) begin
               nxt.use_right_hand = 1'b0;
               nxt.last_velocity  = left_velocity;
            end else if (right_velocity >= cfg.push_velocity_min) begin
               nxt.use_right_hand = 1'b1;
               nxt.last_velocity  = right_velocity;
            end else begin
               nxt.last_velocity = (right_velocity > left_velocity) ? right_velocity
                                                                    : left_velocity;
            end
            if (left_velocity >= cfg.push_velocity_min ||
                right_velocity >= cfg.push_velocity_min) begin
               nxt.phase           = PH_IN;
               nxt.confidence      = 1'b1;
               nxt.gesture_elapsed = '0;
               nxt.phase_elapsed   = '0;
            end
         end
         PH_IN, PH_BOOST, PH_OUT: begin
            nxt.gesture_elapsed = gesture_sat;
            nxt.phase_elapsed   = phase_sat;
            nxt.last_velocity   = tracked;
            if (gesture_sat >= cfg.gesture_time_max) begin
               nxt = STATE_CLEARED;
            end else begin
               case (cur.phase)
                  PH_IN: begin
                     if (tracked < cfg.push_velocity_min) begin
                        nxt = STATE_CLEARED;
                     end else if (phase_sat >= cfg.push_time_min) begin
                        nxt.phase         = PH_BOOST;
                        nxt.confidence    = 1'b1;
                        nxt.phase_elapsed = '0;
                     end
                  end
                  PH_BOOST: begin
                     if (tracked <= cfg.pull_velocity_max) begin
                        nxt.phase         = PH_OUT;
                        nxt.confidence    = 1'b1;
                        nxt.phase_elapsed = '0;
                     end
                  end
                  PH_OUT: begin
                     if (tracked > cfg.pull_velocity_max) begin
                        nxt = STATE_CLEARED;
                     end else if (phase_sat >= cfg.pull_time_min) begin
                        nxt.phase      = PH_TOGGLE;
                        nxt.confidence = 1'b1;
                     end
                  end
                  default: nxt = STATE_CLEARED;
               endcase
            end
         end
         default: nxt = STATE_CLEARED;
      endcase
   end

endmodule

@@ hdl/ppgd_checker.sv @@
// Port-level checks of the gesture detector, bound to the top level.
// Depends on ppgd_pkg and push_pull_gesture_detector_unit.
`timescale 1ns / 1ps

module ppgd_checker
   import ppgd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [PHASE_W-1:0]      rsp_phase,
   input logic                    rsp_confidence,
   input logic signed [VEL_W-1:0] rsp_tracked_velocity
);

   // A held result keeps its payload until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase) &&
                                  $stable(rsp_tracked_velocity))
      else $error("held result changed");

   // Every accepted frame item yields a result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // Input side stalls only behind a result that is not being taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without back-pressure");

   // Only waiting may show zero confidence; phase codes stay in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_confidence || rsp_phase == PH_WAIT) && rsp_phase <= PH_TOGGLE)
      else $error("illegal phase or confidence");

   // A toggled result is followed by a waiting one on the next accepted item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_phase == PH_TOGGLE && req_valid && req_ready
      |=> rsp_phase == PH_WAIT)
      else $error("toggled phase did not reset");

endmodule

bind push_pull_gesture_detector_unit ppgd_checker u_ppgd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_phase            (rsp_ch.phase),
   .rsp_confidence       (rsp_ch.confidence),
   .rsp_tracked_velocity (rsp_ch.tracked_velocity)
);
